### hdl/lpf_pkg.sv
// Shared types and constants for the longest palindrome finder.
`timescale 1ns / 1ps

package lpf_pkg;

  // Depth of the request queue between the front and back parts.
  localparam int unsigned QUEUE_DEPTH = 4;

  typedef struct packed {
    logic [7:0] char_in;
    logic       is_last;
  } char_req_t;

  typedef struct packed {
    logic [7:0] pal_start;
    logic [8:0] pal_length;
    logic       overflowed;
  } result_t;

  // Classified request handed from the front part to the back part.
  typedef struct packed {
    logic [7:0] char_in;
    logic       is_last;
    logic       keep;       // byte fits in the store
    logic       overflowed; // string has overflowed up to and including this byte
  } queue_entry_t;

  typedef enum logic [2:0] {
    ST_LOAD,
    ST_SETUP,
    ST_READ,
    ST_CMP,
    ST_FIN,
    ST_DONE
  } scan_state_t;

endpackage

### hdl/lpf_ram.sv
// Generic simple dual-read RAM with one write port and registered reads.
`timescale 1ns / 1ps

module lpf_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr_a,
  input  logic [$clog2(DEPTH)-1:0] raddr_b,
  output logic [WIDTH-1:0]         rdata_a,
  output logic [WIDTH-1:0]         rdata_b
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_a <= mem[raddr_a];
    rdata_b <= mem[raddr_b];
  end

endmodule

### hdl/lpf_front.sv
// Front part: accepts byte requests and classifies them as kept or dropped.
`timescale 1ns / 1ps

module lpf_front #(
  parameter int unsigned MAX_LEN = 256
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  char_valid,
  output logic                  char_stall,
  input  lpf_pkg::char_req_t    char_req,
  input  logic                  queue_full,
  output logic                  push,
  output lpf_pkg::queue_entry_t push_entry
);

  localparam int unsigned NW = $clog2(MAX_LEN + 1);

  logic [NW-1:0] count;
  logic          overflow;
  logic          keep;

  assign char_stall = queue_full;
  assign push       = char_valid && !queue_full;
  assign keep       = (count != NW'(MAX_LEN));

  always_comb begin
    push_entry.char_in    = char_req.char_in;
    push_entry.is_last    = char_req.is_last;
    push_entry.keep       = keep;
    push_entry.overflowed = overflow || !keep;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count    <= '0;
      overflow <= 1'b0;
    end else if (push) begin
      if (char_req.is_last) begin
        count    <= '0;
        overflow <= 1'b0;
      end else if (keep) begin
        count <= count + 1'b1;
      end else begin
        overflow <= 1'b1;
      end
    end
  end

endmodule

### hdl/lpf_queue.sv
// Short request queue between the front and back parts.
`timescale 1ns / 1ps

module lpf_queue (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  push,
  input  lpf_pkg::queue_entry_t push_entry,
  output logic                  full,
  input  logic                  pop,
  output logic                  empty,
  output lpf_pkg::queue_entry_t pop_entry
);

  localparam int unsigned PW = $clog2(lpf_pkg::QUEUE_DEPTH);
  localparam int unsigned CW = $clog2(lpf_pkg::QUEUE_DEPTH + 1);

  lpf_pkg::queue_entry_t slots [lpf_pkg::QUEUE_DEPTH];
  logic [PW-1:0] wr_ptr;
  logic [PW-1:0] rd_ptr;
  logic [CW-1:0] fill;

  assign full      = (fill == CW'(lpf_pkg::QUEUE_DEPTH));
  assign empty     = (fill == '0);
  assign pop_entry = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      case ({push, pop})
        2'b10:   fill <= fill + 1'b1;
        2'b01:   fill <= fill - 1'b1;
        default: fill <= fill;
      endcase
    end
  end

endmodule

### hdl/lpf_back.sv
// Back part: stores bytes, scans all centers and holds the result register.
`timescale 1ns / 1ps

module lpf_back #(
  parameter int unsigned MAX_LEN = 256
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  queue_empty,
  input  lpf_pkg::queue_entry_t pop_entry,
  output logic                  pop,
  output logic                  result_valid,
  input  logic                  result_stall,
  output lpf_pkg::result_t      result
);

  localparam int unsigned AW = $clog2(MAX_LEN);
  localparam int unsigned NW = $clog2(MAX_LEN + 1);

  lpf_pkg::scan_state_t state;
  lpf_pkg::scan_state_t state_next;

  logic [NW-1:0] wr_count;
  logic [NW-1:0] n;
  logic          overflow;
  logic [AW-1:0] center;
  logic          odd;
  logic [AW-1:0] lo;
  logic [AW-1:0] hi;
  logic [NW-1:0] len;
  logic [AW-1:0] best_start;
  logic [NW-1:0] best_len;

  logic          ram_we;
  logic          res_load;
  logic [7:0]    rd_lo;
  logic [7:0]    rd_hi;

  logic [NW-1:0] center_inc;
  logic [NW-1:0] hi_inc;
  logic          chars_match;
  logic          edge_hit;

  assign center_inc  = NW'(center) + 1'b1;
  assign hi_inc      = NW'(hi) + 1'b1;
  assign chars_match = (rd_lo == rd_hi);
  assign edge_hit    = (lo == '0) || (hi_inc >= n);

  lpf_ram #(
    .WIDTH (8),
    .DEPTH (MAX_LEN)
  ) u_store (
    .clk     (clk),
    .we      (ram_we),
    .waddr   (wr_count[AW-1:0]),
    .wdata   (pop_entry.char_in),
    .raddr_a (lo),
    .raddr_b (hi),
    .rdata_a (rd_lo),
    .rdata_b (rd_hi)
  );

  // Next state.
  always_comb begin
    state_next = state;
    case (state)
      lpf_pkg::ST_LOAD: begin
        if (!queue_empty && pop_entry.is_last) begin
          state_next = lpf_pkg::ST_SETUP;
        end
      end
      lpf_pkg::ST_SETUP: begin
        if (!odd) begin
          state_next = (center_inc >= n) ? lpf_pkg::ST_FIN : lpf_pkg::ST_READ;
        end else begin
          state_next = ((center == '0) || (center_inc >= n)) ? lpf_pkg::ST_FIN
                                                             : lpf_pkg::ST_READ;
        end
      end
      lpf_pkg::ST_READ: begin
        state_next = lpf_pkg::ST_CMP;
      end
      lpf_pkg::ST_CMP: begin
        state_next = (chars_match && !edge_hit) ? lpf_pkg::ST_READ : lpf_pkg::ST_FIN;
      end
      lpf_pkg::ST_FIN: begin
        if (odd && (center_inc == n)) begin
          state_next = lpf_pkg::ST_DONE;
        end else begin
          state_next = lpf_pkg::ST_SETUP;
        end
      end
      lpf_pkg::ST_DONE: begin
        if (!result_valid || !result_stall) begin
          state_next = lpf_pkg::ST_LOAD;
        end
      end
      default: state_next = lpf_pkg::ST_LOAD;
    endcase
  end

  // Control outputs.
  always_comb begin
    pop      = 1'b0;
    ram_we   = 1'b0;
    res_load = 1'b0;
    case (state)
      lpf_pkg::ST_LOAD: begin
        pop    = !queue_empty;
        ram_we = !queue_empty && pop_entry.keep;
      end
      lpf_pkg::ST_DONE: begin
        res_load = !result_valid || !result_stall;
      end
      default: begin
        pop = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= lpf_pkg::ST_LOAD;
      wr_count <= '0;
    end else begin
      state <= state_next;
      if (pop) begin
        if (pop_entry.is_last) begin
          wr_count <= '0;
        end else if (pop_entry.keep) begin
          wr_count <= wr_count + 1'b1;
        end
      end
    end
  end

  // Scan datapath.
  always_ff @(posedge clk) begin
    case (state)
      lpf_pkg::ST_LOAD: begin
        if (pop && pop_entry.is_last) begin
          n          <= wr_count + NW'(pop_entry.keep);
          overflow   <= pop_entry.overflowed;
          center     <= '0;
          odd        <= 1'b0;
          best_start <= '0;
          best_len   <= '0;
        end
      end
      lpf_pkg::ST_SETUP: begin
        if (!odd) begin
          len <= '0;
          lo  <= center;
          hi  <= AW'(center_inc);
        end else begin
          len <= NW'(1);
          lo  <= center - 1'b1;
          hi  <= AW'(center_inc);
        end
      end
      lpf_pkg::ST_CMP: begin
        if (chars_match) begin
          len <= len + NW'(2);
          if (!edge_hit) begin
            lo <= lo - 1'b1;
            hi <= hi + 1'b1;
          end
        end
      end
      lpf_pkg::ST_FIN: begin
        if (len > best_len) begin
          best_len   <= len;
          best_start <= center - AW'((len - 1'b1) >> 1);
        end
        odd <= !odd;
        if (odd) begin
          center <= AW'(center_inc);
        end
      end
      default: begin
        len <= len;
      end
    endcase
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (res_load) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_load) begin
      result.pal_start  <= 8'(best_start);
      result.pal_length <= 9'(best_len);
      result.overflowed <= overflow;
    end
  end

endmodule

### hdl/longest_palindrome_finder_top.sv
// Top level of the longest palindrome finder.
`timescale 1ns / 1ps

// A string arrives on the char channel as one request per byte, with is_last
// marking the final byte. Up to MAX_LEN bytes are kept; later bytes are
// dropped and the result reports overflowed. After the last byte the block
// expands around every center, even then odd, and returns one request on the
// result channel: start and length of the leftmost longest palindrome.
// The front part takes one byte per cycle into a four-entry queue while the
// queue is not full; the back part drains the queue one entry per cycle into
// the byte store while it loads a string. The scan compares one byte pair at
// a time through the store's single read pair, so it runs longest when all
// bytes are equal. While the back part scans, the queue fills and then
// char_stall rises. The result sits in an output register; if result_stall
// is high the result holds there and the back part waits before taking the
// next string, while the front part keeps filling the queue. Synchronous
// reset clears the byte counts, the queue and the result valid; store
// contents are not reset.

module longest_palindrome_finder_top #(
  parameter int unsigned MAX_LEN = 256
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               char_valid,
  output logic               char_stall,
  input  lpf_pkg::char_req_t char_req,
  output logic               result_valid,
  input  logic               result_stall,
  output lpf_pkg::result_t   result
);

  logic                  push;
  logic                  pop;
  logic                  queue_full;
  logic                  queue_empty;
  lpf_pkg::queue_entry_t push_entry;
  lpf_pkg::queue_entry_t pop_entry;

  // Front: handshake and keep/drop classification of each byte.
  lpf_front #(
    .MAX_LEN (MAX_LEN)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .char_valid (char_valid),
    .char_stall (char_stall),
    .char_req   (char_req),
    .queue_full (queue_full),
    .push       (push),
    .push_entry (push_entry)
  );

  // Queue lets the front keep accepting bytes while the back scans.
  lpf_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_entry (push_entry),
    .full       (queue_full),
    .pop        (pop),
    .empty      (queue_empty),
    .pop_entry  (pop_entry)
  );

  // Back: byte store, center expansion scan and the result register.
  lpf_back #(
    .MAX_LEN (MAX_LEN)
  ) u_back (
    .clk          (clk),
    .rst          (rst),
    .queue_empty  (queue_empty),
    .pop_entry    (pop_entry),
    .pop          (pop),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result)
  );

endmodule

### tb/longest_palindrome_finder_top_tb.sv
// Self-checking testbench for the longest palindrome finder.
`timescale 1ns / 1ps

module longest_palindrome_finder_top_tb;

  localparam int unsigned MAX_LEN = 256;
  localparam int unsigned HOLD_CYCLES = 600;
  localparam int unsigned SETTLE_CYCLES = 40;

  typedef logic [7:0] char_list_t[$];

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               char_valid = 1'b0;
  logic               char_stall;
  lpf_pkg::char_req_t char_req = '0;
  logic               result_valid;
  logic               result_stall = 1'b0;
  lpf_pkg::result_t   result;

  longest_palindrome_finder_top #(
    .MAX_LEN(MAX_LEN)
  ) dut (
    .clk(clk),
    .rst(rst),
    .char_valid(char_valid),
    .char_stall(char_stall),
    .char_req(char_req),
    .result_valid(result_valid),
    .result_stall(result_stall),
    .result(result)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Bytes waiting to be offered, and the results the predictor expects.
  lpf_pkg::char_req_t pending_chars[$];
  lpf_pkg::result_t   expected_palindromes[$];

  // Predictor state: the string held so far.
  logic [7:0]  held_bytes[MAX_LEN];
  int unsigned held_count = 0;
  logic        held_overflow = 1'b0;

  int unsigned send_idle_pct = 0;
  int unsigned recv_stall_pct = 0;
  int unsigned hold_left = 0;
  logic        hold_go = 1'b0;
  int unsigned error_count = 0;

  // Length of the palindrome grown outward from the center (lo, hi).
  function automatic int unsigned mirror_len(int lo, int hi, int n);
    int unsigned len;
    len = 0;
    if (lo == hi) begin
      len = 1;
      lo--;
      hi++;
    end
    while (lo >= 0 && hi < n && held_bytes[lo] == held_bytes[hi]) begin
      len += 2;
      lo--;
      hi++;
    end
    return len;
  endfunction

  // Takes one accepted request; on the final byte it scans every center and
  // queues the leftmost longest palindrome.
  function automatic void absorb_char(lpf_pkg::char_req_t req);
    int unsigned      best_start, best_len, even_len, odd_len, len;
    lpf_pkg::result_t res;
    if (held_count < MAX_LEN) begin
      held_bytes[held_count] = req.char_in;
      held_count++;
    end else begin
      held_overflow = 1'b1;
    end
    if (req.is_last) begin
      best_start = 0;
      best_len = 0;
      for (int i = 0; i < int'(held_count); i++) begin
        even_len = mirror_len(i, i + 1, int'(held_count));
        odd_len = mirror_len(i, i, int'(held_count));
        len = (even_len > odd_len) ? even_len : odd_len;
        if (len > best_len) begin
          best_start = i - (len - 1) / 2;
          best_len = len;
        end
      end
      res.pal_start = best_start[7:0];
      res.pal_length = best_len[8:0];
      res.overflowed = held_overflow;
      expected_palindromes.push_back(res);
      held_count = 0;
      held_overflow = 1'b0;
    end
  endfunction

  function automatic void queue_string(char_list_t s);
    lpf_pkg::char_req_t req;
    foreach (s[i]) begin
      req.char_in = s[i];
      req.is_last = (i == s.size() - 1);
      pending_chars.push_back(req);
    end
  endfunction

  // Random string: either fully random bytes, a small alphabet that breeds
  // embedded palindromes, or a whole palindrome with random content.
  function automatic int unsigned queue_random_string();
    char_list_t  s;
    int unsigned len, mode, base, spread;
    len = ($urandom_range(9) == 0) ? $urandom_range(40, 13) : $urandom_range(12, 1);
    mode = $urandom_range(2);
    base = $urandom_range(255);
    spread = $urandom_range(2);
    for (int unsigned i = 0; i < len; i++) begin
      if (mode == 0)
        s.push_back(8'($urandom_range(255)));
      else if (mode == 1)
        s.push_back(8'(base + $urandom_range(spread)));
      else if (i < (len + 1) / 2)
        s.push_back(8'($urandom_range(255)));
      else
        s.push_back(s[len - 1 - i]);
    end
    queue_string(s);
    return len;
  endfunction

  // Sender: offer the next byte once the current one is taken.
  always @(posedge clk) begin
    if (rst) begin
      char_valid <= 1'b0;
    end else if (!char_valid || !char_stall) begin
      if (char_valid) absorb_char(char_req);
      if (pending_chars.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        char_req <= pending_chars.pop_front();
        char_valid <= 1'b1;
      end else begin
        char_valid <= 1'b0;
      end
    end
  end

  // Long receiver hold-off, counted here so the block backs up into its queue.
  always @(posedge clk) begin
    if (rst) begin
      hold_left <= 0;
    end else if (hold_go) begin
      hold_left <= HOLD_CYCLES;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end
  end

  // Receiver: check each accepted result against the oldest expectation.
  always @(posedge clk) begin
    lpf_pkg::result_t want;
    if (rst) begin
      result_stall <= 1'b0;
    end else begin
      if (result_valid && !result_stall) begin
        if (expected_palindromes.size() == 0) begin
          $error("unexpected result: start %0d length %0d overflowed %0d",
                 result.pal_start, result.pal_length, result.overflowed);
          error_count++;
        end else begin
          want = expected_palindromes.pop_front();
          if (result.pal_start !== want.pal_start) begin
            $error("pal_start mismatch: expected %0d, actual %0d",
                   want.pal_start, result.pal_start);
            error_count++;
          end
          if (result.pal_length !== want.pal_length) begin
            $error("pal_length mismatch: expected %0d, actual %0d",
                   want.pal_length, result.pal_length);
            error_count++;
          end
          if (result.overflowed !== want.overflowed) begin
            $error("overflowed mismatch: expected %0d, actual %0d",
                   want.overflowed, result.overflowed);
            error_count++;
          end
        end
      end
      result_stall <= (hold_left != 0) || ($urandom_range(99) < recv_stall_pct);
    end
  end

  // Waits until every byte is taken and every expected result has come.
  task automatic settle();
    while (pending_chars.size() != 0 || char_valid || expected_palindromes.size() != 0)
      @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic random_phase(int unsigned send_pct, int unsigned recv_pct,
                              int unsigned chars);
    int unsigned queued;
    queued = 0;
    send_idle_pct = send_pct;
    recv_stall_pct = recv_pct;
    while (queued < chars) queued += queue_random_string();
    settle();
  endtask

  initial begin
    char_list_t s;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed: byte extremes, even and odd centers, leftmost tie, and a
    // strictly longer palindrome found late.
    queue_string('{8'h00});
    queue_string('{8'hFF});
    queue_string('{8'h55, 8'h55});
    queue_string('{8'h00, 8'hFF, 8'h00});
    queue_string('{8'h01, 8'h02, 8'h03, 8'h04});
    queue_string('{8'h10, 8'hAA, 8'h55, 8'h55, 8'hAA, 8'h20});
    queue_string('{8'h07, 8'h08, 8'h08, 8'h09, 8'h09, 8'h09});
    settle();

    // A full store of one byte gives the longest possible palindrome.
    s.delete();
    for (int i = 0; i < MAX_LEN; i++) s.push_back(8'hA5);
    queue_string(s);
    settle();

    // Too many bytes: the tail is dropped, the final byte among the dropped.
    s.delete();
    for (int i = 0; i < MAX_LEN + 2; i++) s.push_back(8'($urandom_range(1)));
    queue_string(s);
    settle();

    // The receiver holds off while short strings keep coming, so the block's
    // queue fills and it stalls its input.
    for (int i = 0; i < 8; i++) queue_string('{8'h31, 8'h32, 8'h31});
    hold_go = 1'b1;
    @(negedge clk);
    hold_go = 1'b0;
    settle();

    random_phase(0, 0, 30);
    random_phase(78, 0, 30);
    random_phase(0, 78, 30);
    random_phase(36, 36, 30);
    random_phase(0, 0, 30);

    if (error_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  initial begin
    #1000000;
    $display("status: fail");
    $finish;
  end

endmodule

### longest_palindrome_finder_top.f
hdl/lpf_pkg.sv
hdl/lpf_ram.sv
hdl/lpf_front.sv
hdl/lpf_queue.sv
hdl/lpf_back.sv
hdl/longest_palindrome_finder_top.sv
tb/longest_palindrome_finder_top_tb.sv
